@@ rtl/tbps_pkg.sv @@
// types and constants shared by the token bucket shaper files
package tbps_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned TOKEN_W = 16;
    localparam int unsigned OUT_W   = 3;
    localparam int unsigned LEVEL_W = 7;

    // outcome codes
    localparam logic [OUT_W-1:0] OUTCOME_QUEUED        = 3'd0;
    localparam logic [OUT_W-1:0] OUTCOME_DROP_OVERSIZE = 3'd1;
    localparam logic [OUT_W-1:0] OUTCOME_DROP_FULL     = 3'd2;
    localparam logic [OUT_W-1:0] OUTCOME_TOKEN_ADDED   = 3'd3;
    localparam logic [OUT_W-1:0] OUTCOME_TOKEN_DROPPED = 3'd4;

    // event kinds
    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam logic [TOKEN_W-1:0] DEPTH_RESET = 16'd10;

    typedef struct packed {
        logic               mode;
        logic [ID_W-1:0]    packet_id;
        logic [TOKEN_W-1:0] tokens_needed;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_W-1:0]   outcome;
        logic               released;
        logic [ID_W-1:0]    released_id;
        logic [TOKEN_W-1:0] tokens_now;
        logic [LEVEL_W-1:0] queue_level;
    } out_beat_t;

    // one waiting packet
    typedef struct packed {
        logic [TOKEN_W-1:0] need;
        logic [ID_W-1:0]    id;
    } entry_t;

endpackage

@@ rtl/token_bucket_packet_shaper.sv @@
// top level of the token bucket packet shaper with its waiting queue
//
// usage
// - one event beat on cmd is taken at each rising edge with start high and busy low;
//   busy is always low, so an event may be issued in every cycle
// - an event is a packet arrival (id and token need) or a single token tick
// - every event gives exactly one result beat on result, marked by done for one cycle
// - the event is registered, then evaluated against the bucket and the queue head
//   and the result registered
// - throughput is one event per cycle; the queue head is kept ready by a registered
//   read of the store at the head pointer, with bypass of a same-cycle write
// - the receiver cannot stall: done marks each result beat for one cycle only
// - cfg_wr_en with cfg_wr_data sets bucket_depth, to be written only while idle
// - reset empties the bucket and the queue and sets bucket_depth to ten;
//   the store itself is not cleared, entries are only read once written
// - at most one packet leaves the queue per event
module token_bucket_packet_shaper
    import tbps_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  in_beat_t           cmd,
    input  logic               cfg_wr_en,
    input  logic [TOKEN_W-1:0] cfg_wr_data,
    output logic               done,
    output out_beat_t          result
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] FULL_LVL = LW'(QUEUE_DEPTH);

    // input register
    logic     in_valid_reg;
    in_beat_t in_reg;

    // shaper state
    logic [TOKEN_W-1:0] depth_reg;
    logic [TOKEN_W-1:0] tokens_reg, tokens_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [LW-1:0]      level_reg, level_next;

    // result register
    logic      done_reg;
    out_beat_t result_reg, result_next;

    // evaluation signals
    logic               is_tick;
    logic               oversize;
    logic               queue_full;
    logic               push;
    logic               pop;
    logic               bucket_room;
    logic [TOKEN_W-1:0] tokens_mid;
    logic [LW-1:0]      level_mid;
    entry_t             arrival;
    entry_t             head_entry;
    entry_t             store_head;
    logic [31:0]        level_wide;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            depth_reg <= cfg_wr_data;
        end
    end

    assign arrival.need = in_reg.tokens_needed;
    assign arrival.id   = in_reg.packet_id;

    always_comb
    begin
        is_tick     = (in_reg.mode == MODE_TICK);
        oversize    = (in_reg.tokens_needed > depth_reg);
        queue_full  = (level_reg == FULL_LVL);
        bucket_room = (tokens_reg < depth_reg);
        push        = in_valid_reg && !is_tick && !oversize && !queue_full;

        // tick first, then the head test on the updated bucket
        if (in_valid_reg && is_tick && bucket_room)
        begin
            tokens_mid = tokens_reg + 1'b1;
        end
        else
        begin
            tokens_mid = tokens_reg;
        end
        level_mid = level_reg + LW'(push);

        // empty queue: the packet just arrived is the head
        if (level_reg == '0)
        begin
            head_entry = arrival;
        end
        else
        begin
            head_entry = store_head;
        end

        pop = in_valid_reg && (level_mid != '0) && (head_entry.need <= tokens_mid);

        tokens_next = pop ? (tokens_mid - head_entry.need) : tokens_mid;
        level_next  = level_mid - LW'(pop);

        if (pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        else
        begin
            head_next = head_reg;
        end

        if (push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        else
        begin
            tail_next = tail_reg;
        end

        if (is_tick)
        begin
            result_next.outcome = bucket_room ? OUTCOME_TOKEN_ADDED : OUTCOME_TOKEN_DROPPED;
        end
        else if (oversize)
        begin
            result_next.outcome = OUTCOME_DROP_OVERSIZE;
        end
        else if (queue_full)
        begin
            result_next.outcome = OUTCOME_DROP_FULL;
        end
        else
        begin
            result_next.outcome = OUTCOME_QUEUED;
        end

        level_wide              = 32'(level_next);
        result_next.released    = pop;
        result_next.released_id = pop ? head_entry.id : '0;
        result_next.tokens_now  = tokens_next;
        result_next.queue_level = level_wide[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokens_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            level_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            tokens_reg <= tokens_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            level_reg  <= level_next;
            done_reg   <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // store read follows the next head pointer so the head is ready every cycle
    tbps_fifo_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (tail_reg),
        .wr_data (arrival),
        .rd_addr (head_next),
        .rd_data (store_head)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/tbps_fifo_ram.sv @@
// waiting packet store: one write port, one registered read port with write bypass
module tbps_fifo_ram
    import tbps_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a write to the slot being read shows up at once
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/token_bucket_packet_shaper_test.sv @@
// self-checking testbench for the token bucket packet shaper
`timescale 1ns / 100ps

module token_bucket_packet_shaper_test;
    import tbps_pkg::*;

    localparam int QUEUE_SLOTS  = 64;
    // cycles with no beat in or out before the run is declared hung
    localparam int QUIET_LIMIT  = 400;
    // settle time after the last result before a register write or the end
    localparam int SETTLE_TICKS = 4;

    // scoreboard: keeps its own bucket and waiting queue, predicts one
    // result beat per accepted event and checks the block's beats in order
    class shaper_scoreboard;
        logic [TOKEN_W-1:0] bucket_depth;
        logic [TOKEN_W-1:0] tokens_held;
        entry_t             waiting[$];
        out_beat_t          due[$];
        int                 errors;

        function new();
            bucket_depth = DEPTH_RESET;
            tokens_held  = '0;
            errors       = 0;
        endfunction

        // one event in, one predicted result beat out
        function void note_event(in_beat_t ev);
            out_beat_t exp;
            entry_t    slot;
            exp = '0;
            if (ev.mode == MODE_ARRIVAL)
            begin
                if (ev.tokens_needed > bucket_depth)
                    exp.outcome = OUTCOME_DROP_OVERSIZE;
                else if (waiting.size() >= QUEUE_SLOTS)
                    exp.outcome = OUTCOME_DROP_FULL;
                else
                begin
                    slot.need = ev.tokens_needed;
                    slot.id   = ev.packet_id;
                    waiting.push_back(slot);
                    exp.outcome = OUTCOME_QUEUED;
                end
            end
            else if (tokens_held < bucket_depth)
            begin
                tokens_held = tokens_held + 1'b1;
                exp.outcome = OUTCOME_TOKEN_ADDED;
            end
            else
                exp.outcome = OUTCOME_TOKEN_DROPPED;

            // only the head is tested, and at most one packet leaves
            if (waiting.size() > 0 && waiting[0].need <= tokens_held)
            begin
                tokens_held     = tokens_held - waiting[0].need;
                exp.released    = 1'b1;
                exp.released_id = waiting[0].id;
                void'(waiting.pop_front());
            end
            exp.tokens_now  = tokens_held;
            exp.queue_level = LEVEL_W'(waiting.size());
            due.push_back(exp);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t exp;
            if (due.size() == 0)
            begin
                $error("result beat with nothing outstanding: %h", got);
                errors++;
                return;
            end
            exp = due.pop_front();
            if (got.outcome !== exp.outcome)
            begin
                $error("outcome: expected %0d, got %0d", exp.outcome, got.outcome);
                errors++;
            end
            if (got.released !== exp.released)
            begin
                $error("released: expected %0d, got %0d", exp.released, got.released);
                errors++;
            end
            if (got.released_id !== exp.released_id)
            begin
                $error("released_id: expected %h, got %h", exp.released_id, got.released_id);
                errors++;
            end
            if (got.tokens_now !== exp.tokens_now)
            begin
                $error("tokens_now: expected %0d, got %0d", exp.tokens_now, got.tokens_now);
                errors++;
            end
            if (got.queue_level !== exp.queue_level)
            begin
                $error("queue_level: expected %0d, got %0d", exp.queue_level, got.queue_level);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    in_beat_t           cmd;
    logic               cfg_wr_en;
    logic [TOKEN_W-1:0] cfg_wr_data;
    logic               done;
    out_beat_t          result;

    shaper_scoreboard sb;
    int               quiet_cycles = 0;
    int               burst_left;

    token_bucket_packet_shaper #(
        .QUEUE_DEPTH (QUEUE_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // sample at the rising edge: an event beat taken here is noted before
    // any result beat is checked, so a result in the same cycle as its event would still pair up
    always @(posedge clk)
    begin
        if (start && !busy && rst_n)
            sb.note_event(cmd);
        if (done)
            sb.check_result(result);
        if ((start && !busy && rst_n) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("token_bucket_packet_shaper: mismatch");
        $finish;
    end

    // junk on cmd while start is low, so the block must ignore it
    function automatic in_beat_t random_beat();
        in_beat_t b;
        b.mode          = 1'($urandom);
        b.packet_id     = $urandom;
        b.tokens_needed = 16'($urandom);
        return b;
    endfunction

    // a tick carries random id and need bits, which the block ignores
    function automatic in_beat_t make_tick();
        in_beat_t b;
        b      = random_beat();
        b.mode = MODE_TICK;
        return b;
    endfunction

    function automatic in_beat_t make_arrival(logic [ID_W-1:0] id,
                                              logic [TOKEN_W-1:0] need);
        in_beat_t b;
        b.mode          = MODE_ARRIVAL;
        b.packet_id     = id;
        b.tokens_needed = need;
        return b;
    endfunction

    // sender pacing: bursts of random length, gaps of random length between
    // them; about a quarter of the gaps are empty, giving back-to-back runs
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                cmd   <= random_beat();
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // one event beat; start stays high on return, the caller either issues
    // the next beat or lowers start at this same falling edge
    task automatic issue(in_beat_t ev);
        pace();
        start <= 1'b1;
        cmd   <= ev;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    // register write only once the block has gone quiet
    task automatic set_bucket_depth(logic [TOKEN_W-1:0] depth);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= depth;
        sb.bucket_depth = depth;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random events: ticks, oversize tries with any 16-bit need, and
    // arrivals with needs the current depth can honour
    task automatic run_phase(int items, int tick_pct, int over_pct, int need_cap);
        int roll;
        for (int i = 0; i < items; i++)
        begin
            roll = $urandom_range(99);
            if (roll < tick_pct)
                issue(make_tick());
            else if (roll < tick_pct + over_pct)
                issue(make_arrival($urandom, 16'($urandom)));
            else
                issue(make_arrival($urandom, 16'($urandom_range(need_cap, 1))));
        end
    endtask

    initial
    begin
        int rand_depth;
        sb           = new();
        burst_left   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = DEPTH_RESET;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, depth still at its reset value of ten
        // zero need: released at once even though the bucket is empty
        issue(make_arrival(32'hFFFF_FFFF, 16'd0));
        issue(make_tick());
        // oversize, just over the depth and at the top of the need range
        issue(make_arrival(32'h0000_0000, 16'd11));
        issue(make_arrival(32'h0000_0001, 16'hFFFF));
        // need equal to the depth waits at the head; a small need waits behind
        issue(make_arrival(32'h8000_0000, 16'd10));
        issue(make_arrival(32'h5555_AAAA, 16'd1));
        // nine ticks fill the bucket and release the head, one more the next
        repeat (10) issue(make_tick());

        // smallest depth: a full bucket drops the tick's token
        set_bucket_depth(16'd1);
        issue(make_tick());
        issue(make_tick());
        issue(make_arrival(32'hAAAA_5555, 16'd1));

        // largest depth, then lowered below the token count with a head
        // that no longer fits: ticks drop and everything behind it waits
        set_bucket_depth(16'hFFFF);
        issue(make_arrival(32'h1234_5678, 16'd20));
        issue(make_tick());
        issue(make_tick());
        set_bucket_depth(16'd1);
        issue(make_tick());
        issue(make_arrival(32'h0F0F_F0F0, 16'd2));
        issue(make_arrival(32'hF0F0_0F0F, 16'd1));

        // random part
        // blocked head at depth one: the queue fills and later arrivals bounce
        run_phase(110, 20, 10, 1);
        // widest bucket: the blocked head goes, the queue drains, tokens pile up
        set_bucket_depth(16'hFFFF);
        run_phase(80, 70, 5, 40);
        run_phase(40, 25, 5, 400);
        set_bucket_depth(16'd200);
        run_phase(60, 50, 10, 200);
        // lowered below the count again, mostly dropped ticks at first
        set_bucket_depth(16'd3);
        run_phase(60, 50, 15, 3);
        rand_depth = $urandom_range(64, 4);
        set_bucket_depth(16'(rand_depth));
        run_phase(60, 45, 10, rand_depth);
        set_bucket_depth(DEPTH_RESET);
        run_phase(50, 50, 10, 10);

        drain();
        repeat (SETTLE_TICKS) @(negedge clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("token_bucket_packet_shaper: match");
        else
            $display("token_bucket_packet_shaper: mismatch");
        $finish;
    end

endmodule
